FILE: src/hrmr_pkg.sv
`timescale 1ns / 1ps

package hrmr_pkg;

    localparam int REPORT_BYTES = 64;
    localparam int POS_W        = 6;
    localparam int LEN_W        = 13;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = 2;

    localparam logic [POS_W-1:0] REPORT_LAST  = 6'd63;
    localparam logic [POS_W-1:0] START_CHUNK  = 6'd57;
    localparam logic [POS_W-1:0] CONT_CHUNK   = 6'd59;
    localparam logic [POS_W-1:0] START_OFFSET = 6'd7;
    localparam logic [POS_W-1:0] CONT_OFFSET  = 6'd5;
    localparam logic [LEN_W-1:0] START_CHUNK_LEN = 13'd57;
    localparam logic [LEN_W-1:0] CONT_CHUNK_LEN  = 13'd59;

    localparam logic [7:0] INIT_REPLY_LEN  = 8'd17;
    localparam logic [7:0] ERR_REPLY_LEN   = 8'h01;
    localparam logic [7:0] ERR_INVALID_LEN = 8'h03;
    localparam logic [7:0] PROTO_VERSION   = 8'h02;
    localparam logic [7:0] BUILD_MAJOR     = 8'h01;
    localparam logic [7:0] CAPABILITIES    = 8'h04;

    localparam logic [1:0] CFG_ASSIGNED_CHANNEL = 2'd0;
    localparam logic [1:0] CFG_INIT_CODE        = 2'd1;
    localparam logic [1:0] CFG_ERROR_CODE_CMD   = 2'd2;

    typedef enum logic [2:0] {
        OP_READ,
        OP_INIT_REPLY,
        OP_ERR_REPLY,
        OP_COMMIT,
        OP_NOTICE
    } op_t;

    typedef enum logic [1:0] {
        KIND_REPLY  = 2'd0,
        KIND_NOTICE = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_REPLY
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic [31:0]      chan;
        logic [63:0]      nonce;
        logic [7:0]       command;
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] base;
        logic [POS_W-1:0] count;
        logic [POS_W-1:0] offset;
        logic             bank;
        logic             notice;
        logic [9:0]       read_index;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } buf_wr_t;

    typedef struct packed {
        logic [31:0] assigned_channel;
        logic [7:0]  init_code;
        logic [7:0]  error_code_cmd;
    } cfg_t;

    // Byte at position pos of an init reply (is_init set) or of an error reply.
    function automatic logic [7:0] reply_byte(input logic is_init,
                                              input logic [POS_W-1:0] pos,
                                              input logic [31:0] chan,
                                              input logic [63:0] nonce,
                                              input cfg_t cfg);
        logic [7:0] b;
        b = 8'h00;
        case (pos)
            6'd0:  b = chan[31:24];
            6'd1:  b = chan[23:16];
            6'd2:  b = chan[15:8];
            6'd3:  b = chan[7:0];
            6'd4:  b = is_init ? cfg.init_code : cfg.error_code_cmd;
            6'd6:  b = is_init ? INIT_REPLY_LEN : ERR_REPLY_LEN;
            6'd7:  b = is_init ? nonce[63:56] : ERR_INVALID_LEN;
            6'd8:  b = is_init ? nonce[55:48] : 8'h00;
            6'd9:  b = is_init ? nonce[47:40] : 8'h00;
            6'd10: b = is_init ? nonce[39:32] : 8'h00;
            6'd11: b = is_init ? nonce[31:24] : 8'h00;
            6'd12: b = is_init ? nonce[23:16] : 8'h00;
            6'd13: b = is_init ? nonce[15:8] : 8'h00;
            6'd14: b = is_init ? nonce[7:0] : 8'h00;
            6'd15: b = is_init ? cfg.assigned_channel[31:24] : 8'h00;
            6'd16: b = is_init ? cfg.assigned_channel[23:16] : 8'h00;
            6'd17: b = is_init ? cfg.assigned_channel[15:8] : 8'h00;
            6'd18: b = is_init ? cfg.assigned_channel[7:0] : 8'h00;
            6'd19: b = is_init ? PROTO_VERSION : 8'h00;
            6'd20: b = is_init ? BUILD_MAJOR : 8'h00;
            6'd23: b = is_init ? CAPABILITIES : 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: src/hrmr_cmd_fifo.sv
`timescale 1ns / 1ps

module hrmr_cmd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  hrmr_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output hrmr_pkg::cmd_t  head
);

    localparam int PW = hrmr_pkg::FIFO_PTR_W;

    hrmr_pkg::cmd_t entry_reg [hrmr_pkg::FIFO_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    fill_reg, fill_next;

    assign full  = (fill_reg == (PW+1)'(hrmr_pkg::FIFO_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        fill_next   = fill_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty command queue");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full command queue");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (PW+1)'(hrmr_pkg::FIFO_DEPTH))
        else $error("command queue fill count out of range");

endmodule

FILE: src/hrmr_front.sv
`timescale 1ns / 1ps

module hrmr_front #(
    parameter int MSG_BYTES = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,
    input  logic [0:0]        s_tuser,
    input  logic [7:0]        init_code,
    input  logic              fifo_full,
    output logic              push,
    output hrmr_pkg::cmd_t    push_cmd,
    output hrmr_pkg::buf_wr_t buf_wr,
    input  logic [1:0]        bank_release
);

    localparam int LW = hrmr_pkg::LEN_W;
    localparam int PSW = hrmr_pkg::POS_W;
    localparam logic [15:0] MSG_LIMIT = 16'(MSG_BYTES);

    logic [PSW-1:0] pos_reg, pos_next;
    logic           bank_reg, bank_next;
    logic [1:0]     busy_reg, busy_next;
    logic [31:0]    hdr_chan_reg, hdr_chan_next;
    logic [7:0]     hdr_cmd_reg, hdr_cmd_next;
    logic [15:0]    hdr_len_reg, hdr_len_next;
    logic [63:0]    nonce_reg, nonce_next;
    logic [31:0]    act_chan_reg, act_chan_next;
    logic [7:0]     act_cmd_reg, act_cmd_next;
    logic [LW-1:0]  exp_len_reg, exp_len_next;
    logic [LW-1:0]  rcv_cnt_reg, rcv_cnt_next;
    logic [7:0]     next_seq_reg, next_seq_next;
    logic           receiving_reg, receiving_next;

    logic           accept, is_read, byte_acc, report_end;
    logic [7:0]     rbyte;
    logic           is_start, is_init, too_long, start_ok, cont_ok;
    logic [LW-1:0]  start_len, rem;
    logic [PSW-1:0] start_chunk, cont_chunk;
    logic           start_done, cont_done, commit_push;

    assign s_tready = !fifo_full && !((pos_reg == '0) && busy_reg[bank_reg]);
    assign accept   = s_tvalid && s_tready;
    assign is_read  = s_tuser[0];
    assign rbyte    = s_tdata[7:0];
    assign byte_acc = accept && !is_read;
    assign report_end = byte_acc && (pos_reg == hrmr_pkg::REPORT_LAST);

    // Classification of the finished report; the header is complete long before byte 63.
    always_comb begin
        is_start    = hdr_cmd_reg[7];
        is_init     = is_start && (hdr_cmd_reg == init_code);
        too_long    = is_start && !is_init && (hdr_len_reg > MSG_LIMIT);
        start_ok    = is_start && !is_init && !too_long;
        start_len   = hdr_len_reg[LW-1:0];
        start_done  = (start_len <= hrmr_pkg::START_CHUNK_LEN);
        start_chunk = start_done ? start_len[PSW-1:0] : hrmr_pkg::START_CHUNK;
        cont_ok     = !is_start && receiving_reg && (hdr_chan_reg == act_chan_reg)
                      && (hdr_cmd_reg == next_seq_reg);
        rem         = exp_len_reg - rcv_cnt_reg;
        cont_done   = (rem <= hrmr_pkg::CONT_CHUNK_LEN);
        cont_chunk  = cont_done ? rem[PSW-1:0] : hrmr_pkg::CONT_CHUNK;
        commit_push = report_end && ((start_ok && (start_chunk != '0)) || cont_ok);
    end

    always_comb begin
        push_cmd            = '0;
        push_cmd.op         = hrmr_pkg::OP_READ;
        push_cmd.read_index = s_tdata[17:8];
        push_cmd.chan       = hdr_chan_reg;
        push_cmd.nonce      = nonce_reg;
        push_cmd.command    = is_start ? hdr_cmd_reg : act_cmd_reg;
        push_cmd.length     = is_start ? start_len : exp_len_reg;
        push_cmd.bank       = bank_reg;
        push                = accept && is_read;
        if (report_end) begin
            if (is_init) begin
                push        = 1'b1;
                push_cmd.op = hrmr_pkg::OP_INIT_REPLY;
            end else if (too_long) begin
                push        = 1'b1;
                push_cmd.op = hrmr_pkg::OP_ERR_REPLY;
            end else if (start_ok) begin
                push            = 1'b1;
                push_cmd.op     = (start_chunk == '0) ? hrmr_pkg::OP_NOTICE
                                                      : hrmr_pkg::OP_COMMIT;
                push_cmd.base   = '0;
                push_cmd.offset = hrmr_pkg::START_OFFSET;
                push_cmd.count  = start_chunk;
                push_cmd.notice = start_done;
            end else if (cont_ok) begin
                push            = 1'b1;
                push_cmd.op     = hrmr_pkg::OP_COMMIT;
                push_cmd.base   = rcv_cnt_reg;
                push_cmd.offset = hrmr_pkg::CONT_OFFSET;
                push_cmd.count  = cont_chunk;
                push_cmd.notice = cont_done;
            end
        end
    end

    always_comb begin
        buf_wr.en   = byte_acc;
        buf_wr.bank = bank_reg;
        buf_wr.pos  = pos_reg;
        buf_wr.data = rbyte;
    end

    always_comb begin
        pos_next       = pos_reg;
        hdr_chan_next  = hdr_chan_reg;
        hdr_cmd_next   = hdr_cmd_reg;
        hdr_len_next   = hdr_len_reg;
        nonce_next     = nonce_reg;
        act_chan_next  = act_chan_reg;
        act_cmd_next   = act_cmd_reg;
        exp_len_next   = exp_len_reg;
        rcv_cnt_next   = rcv_cnt_reg;
        next_seq_next  = next_seq_reg;
        receiving_next = receiving_reg;
        busy_next      = busy_reg & ~bank_release;
        bank_next      = bank_reg ^ commit_push;
        if (commit_push) begin
            busy_next[bank_reg] = 1'b1;
        end
        if (byte_acc) begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg < 6'd4) begin
                hdr_chan_next = {hdr_chan_reg[23:0], rbyte};
            end else if (pos_reg == 6'd4) begin
                hdr_cmd_next = rbyte;
            end else if (pos_reg < 6'd7) begin
                hdr_len_next = {hdr_len_reg[7:0], rbyte};
            end else if (pos_reg < 6'd15) begin
                nonce_next = {nonce_reg[55:0], rbyte};
            end
        end
        if (report_end && start_ok) begin
            act_chan_next = hdr_chan_reg;
            act_cmd_next  = hdr_cmd_reg;
            exp_len_next  = start_len;
            rcv_cnt_next  = {{(LW-PSW){1'b0}}, start_chunk};
            if (start_done) begin
                receiving_next = 1'b0;
            end else begin
                next_seq_next  = '0;
                receiving_next = 1'b1;
            end
        end else if (report_end && cont_ok) begin
            rcv_cnt_next  = rcv_cnt_reg + {{(LW-PSW){1'b0}}, cont_chunk};
            next_seq_next = next_seq_reg + 8'd1;
            if (cont_done) begin
                receiving_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            bank_reg      <= 1'b0;
            busy_reg      <= '0;
            hdr_chan_reg  <= '0;
            hdr_cmd_reg   <= '0;
            hdr_len_reg   <= '0;
            nonce_reg     <= '0;
            act_chan_reg  <= '0;
            act_cmd_reg   <= '0;
            exp_len_reg   <= '0;
            rcv_cnt_reg   <= '0;
            next_seq_reg  <= '0;
            receiving_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            bank_reg      <= bank_next;
            busy_reg      <= busy_next;
            hdr_chan_reg  <= hdr_chan_next;
            hdr_cmd_reg   <= hdr_cmd_next;
            hdr_len_reg   <= hdr_len_next;
            nonce_reg     <= nonce_next;
            act_chan_reg  <= act_chan_next;
            act_cmd_reg   <= act_cmd_next;
            exp_len_reg   <= exp_len_next;
            rcv_cnt_reg   <= rcv_cnt_next;
            next_seq_reg  <= next_seq_next;
            receiving_reg <= receiving_next;
        end
    end

    a_no_write_busy_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_wr.en |-> !busy_reg[buf_wr.bank])
        else $error("report byte written into a bank still being drained");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        receiving_reg |-> (rcv_cnt_reg < exp_len_reg))
        else $error("receiving with no bytes outstanding");

    a_commit_toggles_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        commit_push |=> (bank_reg != $past(bank_reg)) && busy_reg[$past(bank_reg)])
        else $error("commit did not reserve its bank");

endmodule

FILE: src/hrmr_back.sv
`timescale 1ns / 1ps

module hrmr_back #(
    parameter int MSG_BYTES = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  hrmr_pkg::cfg_t    cfg,
    input  hrmr_pkg::buf_wr_t buf_wr,
    input  logic              cmd_empty,
    input  hrmr_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    output logic [1:0]        bank_release,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    localparam int LW = hrmr_pkg::LEN_W;
    localparam int PSW = hrmr_pkg::POS_W;
    localparam int ADDR_W = $clog2(MSG_BYTES);
    localparam logic [LW:0] MSG_LIMIT = (LW+1)'(MSG_BYTES);

    logic [7:0] buf_mem   [2*hrmr_pkg::REPORT_BYTES];
    logic [7:0] store_mem [MSG_BYTES];

    hrmr_pkg::back_state_t state_reg, state_next;
    logic [PSW-1:0] rcnt_reg, rcnt_next;
    logic           rinit_reg;
    logic [31:0]    rchan_reg;
    logic [63:0]    rnonce_reg;

    // Drain engine: copies a committed chunk from the report buffer into the store.
    logic           dr_active_reg, dr_bank_reg, dr_wr_valid_reg, dr_wr_last_reg;
    logic [PSW-1:0] dr_off_reg, dr_cnt_reg, dr_i_reg;
    logic [LW-1:0]  dr_base_reg, dr_wr_addr_reg;
    logic [7:0]     dr_rdata_reg;
    logic           dr_idle;

    // Overlay: the committed chunk still readable from the buffer.
    logic           ov_valid_reg, ov_bank_reg;
    logic [PSW-1:0] ov_off_reg, ov_cnt_reg;
    logic [LW-1:0]  ov_base_reg;

    logic           b_valid_reg, b_is_read_reg, b_from_buf_reg, b_zero_reg, b_last_reg;
    hrmr_pkg::kind_t b_kind_reg;
    logic [7:0]     b_data_reg;
    logic [31:0]    b_chan_reg;
    logic [7:0]     b_cmd_reg;
    logic [10:0]    b_len_reg;
    logic [7:0]     store_rdata_reg, ovl_rdata_reg;

    logic           m_valid_reg, m_last_reg;
    logic [63:0]    m_data_reg;
    logic [1:0]     m_user_reg;

    logic           adv_out, b_free;
    logic           emit_reply, issue_read, issue_notice, issue_commit, load_reply;
    logic [LW:0]    ridx_w, ov_lo, ov_hi;
    logic           in_range, ov_hit;
    logic [LW-1:0]  ov_delta;
    logic [6:0]     ovl_addr;
    logic [7:0]     reply_val, b_out_data;

    assign adv_out = !m_valid_reg || m_tready;
    assign b_free  = !b_valid_reg || adv_out;
    assign dr_idle = !dr_active_reg && !dr_wr_valid_reg;

    always_comb begin
        ridx_w   = {{(LW+1-10){1'b0}}, cmd.read_index};
        in_range = ridx_w < MSG_LIMIT;
        ov_lo    = {1'b0, ov_base_reg};
        ov_hi    = ov_lo + {{(LW+1-PSW){1'b0}}, ov_cnt_reg};
        ov_hit   = ov_valid_reg && (ridx_w >= ov_lo) && (ridx_w < ov_hi);
        ov_delta = ridx_w[LW-1:0] - ov_base_reg;
        ovl_addr = {ov_bank_reg, ov_off_reg + ov_delta[PSW-1:0]};
        reply_val = hrmr_pkg::reply_byte(rinit_reg, rcnt_reg, rchan_reg, rnonce_reg, cfg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hrmr_pkg::BK_IDLE: begin
                if (!cmd_empty && ((cmd.op == hrmr_pkg::OP_INIT_REPLY)
                                   || (cmd.op == hrmr_pkg::OP_ERR_REPLY))) begin
                    state_next = hrmr_pkg::BK_REPLY;
                end
            end
            hrmr_pkg::BK_REPLY: begin
                if (b_free && (rcnt_reg == hrmr_pkg::REPORT_LAST)) begin
                    state_next = hrmr_pkg::BK_IDLE;
                end
            end
            default: state_next = hrmr_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        emit_reply   = 1'b0;
        issue_read   = 1'b0;
        issue_notice = 1'b0;
        issue_commit = 1'b0;
        load_reply   = 1'b0;
        cmd_pop      = 1'b0;
        unique case (state_reg)
            hrmr_pkg::BK_REPLY: begin
                emit_reply = b_free;
            end
            hrmr_pkg::BK_IDLE: begin
                if (!cmd_empty) begin
                    unique case (cmd.op)
                        hrmr_pkg::OP_READ: begin
                            issue_read = b_free;
                            cmd_pop    = b_free;
                        end
                        hrmr_pkg::OP_INIT_REPLY, hrmr_pkg::OP_ERR_REPLY: begin
                            load_reply = 1'b1;
                            cmd_pop    = 1'b1;
                        end
                        hrmr_pkg::OP_COMMIT: begin
                            if (dr_idle && (!cmd.notice || b_free)) begin
                                issue_commit = 1'b1;
                                issue_notice = cmd.notice;
                                cmd_pop      = 1'b1;
                            end
                        end
                        hrmr_pkg::OP_NOTICE: begin
                            issue_notice = b_free;
                            cmd_pop      = b_free;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        rcnt_next = load_reply ? '0 : (emit_reply ? rcnt_reg + 1'b1 : rcnt_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hrmr_pkg::BK_IDLE;
            rcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            rcnt_reg  <= rcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_reply) begin
            rinit_reg  <= (cmd.op == hrmr_pkg::OP_INIT_REPLY);
            rchan_reg  <= cmd.chan;
            rnonce_reg <= cmd.nonce;
        end
    end

    // Report buffer: two banks of one report each.
    always_ff @(posedge aclk) begin
        if (buf_wr.en) begin
            buf_mem[{buf_wr.bank, buf_wr.pos}] <= buf_wr.data;
        end
        if (dr_active_reg) begin
            dr_rdata_reg <= buf_mem[{dr_bank_reg, dr_off_reg + dr_i_reg}];
        end
        if (issue_read && ov_hit) begin
            ovl_rdata_reg <= buf_mem[ovl_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (dr_wr_valid_reg && ({1'b0, dr_wr_addr_reg} < MSG_LIMIT)) begin
            store_mem[dr_wr_addr_reg[ADDR_W-1:0]] <= dr_rdata_reg;
        end
        if (issue_read && in_range && !ov_hit) begin
            store_rdata_reg <= store_mem[ridx_w[ADDR_W-1:0]];
        end
    end

    always_comb begin
        bank_release = '0;
        if (dr_wr_valid_reg && dr_wr_last_reg) begin
            bank_release[dr_bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dr_active_reg   <= 1'b0;
            dr_wr_valid_reg <= 1'b0;
            ov_valid_reg    <= 1'b0;
        end else begin
            dr_wr_valid_reg <= dr_active_reg;
            if (issue_commit) begin
                dr_active_reg <= 1'b1;
                ov_valid_reg  <= 1'b1;
            end else begin
                if (dr_active_reg && (dr_i_reg == dr_cnt_reg - 1'b1)) begin
                    dr_active_reg <= 1'b0;
                end
                if (dr_wr_valid_reg && dr_wr_last_reg) begin
                    ov_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_commit) begin
            dr_bank_reg <= cmd.bank;
            dr_off_reg  <= cmd.offset;
            dr_cnt_reg  <= cmd.count;
            dr_base_reg <= cmd.base;
            dr_i_reg    <= '0;
            ov_bank_reg <= cmd.bank;
            ov_off_reg  <= cmd.offset;
            ov_cnt_reg  <= cmd.count;
            ov_base_reg <= cmd.base;
        end else if (dr_active_reg) begin
            dr_i_reg <= dr_i_reg + 1'b1;
        end
        dr_wr_addr_reg <= dr_base_reg + {{(LW-PSW){1'b0}}, dr_i_reg};
        dr_wr_last_reg <= (dr_i_reg == dr_cnt_reg - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_free) begin
            b_valid_reg <= emit_reply || issue_read || issue_notice;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_reply) begin
            b_kind_reg    <= hrmr_pkg::KIND_REPLY;
            b_is_read_reg <= 1'b0;
            b_data_reg    <= reply_val;
            b_chan_reg    <= '0;
            b_cmd_reg     <= '0;
            b_len_reg     <= '0;
            b_last_reg    <= (rcnt_reg == hrmr_pkg::REPORT_LAST);
        end else if (issue_read) begin
            b_kind_reg     <= hrmr_pkg::KIND_READ;
            b_is_read_reg  <= 1'b1;
            b_from_buf_reg <= ov_hit;
            b_zero_reg     <= !in_range;
            b_data_reg     <= '0;
            b_chan_reg     <= '0;
            b_cmd_reg      <= '0;
            b_len_reg      <= '0;
            b_last_reg     <= 1'b0;
        end else if (issue_notice) begin
            b_kind_reg    <= hrmr_pkg::KIND_NOTICE;
            b_is_read_reg <= 1'b0;
            b_data_reg    <= '0;
            b_chan_reg    <= cmd.chan;
            b_cmd_reg     <= cmd.command;
            b_len_reg     <= cmd.length[10:0];
            b_last_reg    <= 1'b0;
        end
    end

    always_comb begin
        if (!b_is_read_reg) begin
            b_out_data = b_data_reg;
        end else if (b_zero_reg) begin
            b_out_data = '0;
        end else begin
            b_out_data = b_from_buf_reg ? ovl_rdata_reg : store_rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv_out) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out && b_valid_reg) begin
            m_data_reg <= {5'd0, b_len_reg, b_cmd_reg, b_chan_reg, b_out_data};
            m_user_reg <= b_kind_reg;
            m_last_reg <= b_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    a_overlay_during_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (dr_active_reg || dr_wr_valid_reg) |-> ov_valid_reg)
        else $error("drain running without an overlay");

    a_commit_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_commit |=> dr_active_reg && !$past(dr_wr_valid_reg))
        else $error("commit started over a running drain");

    a_reply_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_reply && (rcnt_reg != hrmr_pkg::REPORT_LAST)
        |=> (state_reg == hrmr_pkg::BK_REPLY) && (rcnt_reg == $past(rcnt_reg) + 1'b1))
        else $error("reply counter skipped");

endmodule

FILE: src/hid_report_message_reassembler.sv
`timescale 1ns / 1ps

// HID report message reassembler.
// Input words arrive on the s_ channel. s_tuser[0] clear means s_tdata[7:0] is the next
// byte of a 64-byte report; set means s_tdata[17:8] is a message store index to read.
// The block acts on a report when its 64th byte arrives: an init request yields a
// 64-word reply, an oversized start packet a 64-word error reply, and a matching start
// or continuation packet is copied into the message store, followed by a completion
// notice once the announced length has been received. A read yields one word.
// Results leave on the m_ channel; m_tuser gives the kind and m_tlast marks the final
// byte of a reply. The front end takes one input word per cycle while s_tready is high.
// A read result passes through the command queue, the b stage and the output register;
// a reply is loaded from the queue, then sent one word per cycle while m_tready is high.
// Payload bytes of a report are copied into the store by a drain engine at one byte per
// cycle through its single write port, hidden behind the next report in the second bank
// of the report buffer. A report's first byte also waits while its bank is still draining.
// Reset clears all control state and loads the register defaults; no clearing pass is
// run, and never-written store entries read back as unknown. When the receiver holds
// m_tready low, results wait in the output stage and the four-entry command queue, and
// once that queue is full s_tready falls until the receiver resumes.
module hid_report_message_reassembler #(
    parameter int MSG_BYTES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // report_byte [7:0], read_index [17:8]
    input  logic [0:0]  s_tuser,     // req_type [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // data_byte [7:0], msg_channel [39:8],
                                     // msg_command [47:40], msg_len [58:48]
    output logic [1:0]  m_tuser,     // kind [1:0]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data
);

    // Configuration registers, to be written only while the block is idle; the block does not enforce this.
    hrmr_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.assigned_channel <= 32'h0102_0304;
            cfg_reg.init_code        <= 8'h86;
            cfg_reg.error_code_cmd   <= 8'hBF;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                hrmr_pkg::CFG_ASSIGNED_CHANNEL: cfg_reg.assigned_channel <= cfg_wr_data;
                hrmr_pkg::CFG_INIT_CODE:        cfg_reg.init_code <= cfg_wr_data[7:0];
                hrmr_pkg::CFG_ERROR_CODE_CMD:   cfg_reg.error_code_cmd <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    logic              push, fifo_full, fifo_empty, pop;
    hrmr_pkg::cmd_t    push_cmd, head_cmd;
    hrmr_pkg::buf_wr_t buf_wr;
    logic [1:0]        bank_release;

    // The front end tracks the report position and the reassembly state.
    hrmr_front #(
        .MSG_BYTES (MSG_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .init_code    (cfg_reg.init_code),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_cmd     (push_cmd),
        .buf_wr       (buf_wr),
        .bank_release (bank_release)
    );

    hrmr_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .empty    (fifo_empty),
        .head     (head_cmd)
    );

    // The back end owns the buffer and the store and produces every result word.
    hrmr_back #(
        .MSG_BYTES (MSG_BYTES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .buf_wr       (buf_wr),
        .cmd_empty    (fifo_empty),
        .cmd          (head_cmd),
        .cmd_pop      (pop),
        .bank_release (bank_release),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

// One word leaving the m_ channel.
typedef struct {
    hrmr_pkg::kind_t kind;
    logic [7:0]      data_byte;
    logic [31:0]     chan;
    logic [7:0]      command;
    logic [10:0]     length;
    logic            last;
} hid_result_t;

// Keeps its own copy of the reassembler state and turns each accepted word
// into the results the block should produce, then checks them in order.
class reassembly_scoreboard;
    logic [31:0] assigned_chan;
    logic [7:0]  init_cmd;
    logic [7:0]  err_cmd;

    logic [7:0]  store [1024];
    bit          written [1024];
    logic [7:0]  report_buf [64];
    int          pos;
    logic [31:0] hdr_chan;
    logic [7:0]  hdr_cmd;
    logic [15:0] hdr_len;
    logic [63:0] nonce;
    logic [31:0] act_chan;
    logic [7:0]  act_cmd;
    int          want_len;
    int          got_len;
    logic [7:0]  next_seq;
    bit          busy;

    hid_result_t pending [$];
    int          errors;

    function new();
        assigned_chan = 32'h01020304;
        init_cmd = 8'h86;
        err_cmd = 8'hBF;
        foreach (written[i]) written[i] = 0;
        pos = 0;
        hdr_chan = '0;
        hdr_cmd = '0;
        hdr_len = '0;
        nonce = '0;
        act_chan = '0;
        act_cmd = '0;
        want_len = 0;
        got_len = 0;
        next_seq = '0;
        busy = 0;
        errors = 0;
    endfunction

    function void write_reg(logic [1:0] addr, logic [31:0] value);
        case (addr)
            hrmr_pkg::CFG_ASSIGNED_CHANNEL: assigned_chan = value;
            hrmr_pkg::CFG_INIT_CODE:        init_cmd = value[7:0];
            hrmr_pkg::CFG_ERROR_CODE_CMD:   err_cmd = value[7:0];
            default: ;
        endcase
    endfunction

    function void push(hrmr_pkg::kind_t k, logic [7:0] d, logic [31:0] ch,
                       logic [7:0] cmd, logic [10:0] len, logic lst);
        hid_result_t r;
        r.kind = k;
        r.data_byte = d;
        r.chan = ch;
        r.command = cmd;
        r.length = len;
        r.last = lst;
        pending.push_back(r);
    endfunction

    function void push_reply(logic [7:0] rep [64]);
        for (int i = 0; i < 64; i++)
            push(hrmr_pkg::KIND_REPLY, rep[i], '0, '0, '0, i == 63);
    endfunction

    function void complete();
        busy = 0;
        push(hrmr_pkg::KIND_NOTICE, '0, act_chan, act_cmd, want_len[10:0], 0);
    endfunction

    // Acts on a report once its 64th byte has been taken.
    function void end_of_report();
        logic [7:0] rep [64];
        int chunk;
        foreach (rep[i]) rep[i] = '0;
        if (hdr_cmd[7]) begin
            if (hdr_cmd == init_cmd) begin
                {rep[0], rep[1], rep[2], rep[3]} = hdr_chan;
                rep[4] = init_cmd;
                rep[6] = 8'd17;
                for (int i = 0; i < 8; i++) rep[7 + i] = nonce[63 - 8 * i -: 8];
                {rep[15], rep[16], rep[17], rep[18]} = assigned_chan;
                rep[19] = 8'h02;
                rep[20] = 8'h01;
                rep[23] = 8'h04;
                push_reply(rep);
                return;
            end
            if (hdr_len > 1024) begin
                {rep[0], rep[1], rep[2], rep[3]} = hdr_chan;
                rep[4] = err_cmd;
                rep[6] = 8'h01;
                rep[7] = 8'h03;
                push_reply(rep);
                return;
            end
            act_chan = hdr_chan;
            act_cmd = hdr_cmd;
            want_len = hdr_len;
            chunk = want_len > 57 ? 57 : want_len;
            for (int i = 0; i < chunk; i++) begin
                store[i] = report_buf[7 + i];
                written[i] = 1;
            end
            got_len = chunk;
            if (got_len >= want_len) begin
                complete();
                return;
            end
            next_seq = '0;
            busy = 1;
            return;
        end
        if (!busy || hdr_chan != act_chan || hdr_cmd != next_seq) return;
        chunk = want_len - got_len;
        if (chunk > 59) chunk = 59;
        for (int i = 0; i < chunk; i++) begin
            if (got_len + i < 1024) begin
                store[got_len + i] = report_buf[5 + i];
                written[got_len + i] = 1;
            end
        end
        got_len += chunk;
        next_seq = next_seq + 8'd1;
        if (got_len >= want_len) complete();
    endfunction

    function void note_input(bit is_read, logic [7:0] b, logic [9:0] idx);
        if (is_read) begin
            push(hrmr_pkg::KIND_READ, store[idx], '0, '0, '0, 0);
            return;
        end
        report_buf[pos] = b;
        if (pos < 4) hdr_chan = {hdr_chan[23:0], b};
        else if (pos == 4) hdr_cmd = b;
        else if (pos < 7) hdr_len = {hdr_len[7:0], b};
        else if (pos < 15) nonce = {nonce[55:0], b};
        if (pos == 63) begin
            pos = 0;
            end_of_report();
        end else begin
            pos++;
        end
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check(hid_result_t got);
        hid_result_t want;
        if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected word of kind %0d", got.kind));
            return;
        end
        want = pending.pop_front();
        if (got.kind != want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.data_byte != want.data_byte)
            report_mismatch($sformatf("data byte %h, expected %h", got.data_byte,
                                      want.data_byte));
        if (got.chan != want.chan)
            report_mismatch($sformatf("channel %h, expected %h", got.chan, want.chan));
        if (got.command != want.command)
            report_mismatch($sformatf("command %h, expected %h", got.command, want.command));
        if (got.length != want.length)
            report_mismatch($sformatf("length %0d, expected %0d", got.length, want.length));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    endtask
endclass

module testbench;

    localparam int CYCLE_LIMIT = 1000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wr_data;

    reassembly_scoreboard sb;
    bit   calm;          // when set, neither side idles
    int   cycles;
    logic [7:0] rep [64];

    hid_report_message_reassembler dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Every accepted result is checked against the oldest expected one. Signals are
    // sampled at the rising edge, before the block's own updates of that edge land.
    always @(posedge aclk) begin
        hid_result_t r;
        if (aresetn && m_tvalid && m_tready) begin
            r.kind = hrmr_pkg::kind_t'(m_tuser);
            r.data_byte = m_tdata[7:0];
            r.chan = m_tdata[39:8];
            r.command = m_tdata[47:40];
            r.length = m_tdata[58:48];
            r.last = m_tlast;
            sb.check(r);
        end
    end

    // Watchdog: a run that stalls or never drains ends here as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // The receiver stalls at random, changing m_tready on the falling edge only.
    initial begin
        int stall;
        m_tready = 1'b0;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else if (!calm && $urandom_range(99) < 25) begin
                m_tready = 1'b0;
                stall = pick_gap();
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Offers one word after a random gap and waits for it to be taken. The gap is
    // only ever spent with s_tvalid low, so a word that follows straight on keeps
    // s_tvalid high without a second assignment in the same step.
    task automatic send_word(bit is_read, logic [7:0] b, logic [9:0] idx);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = is_read;
        s_tdata = {6'd0, idx, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(is_read, b, idx);
    endtask

    // Reads one stored byte that has been written, if any can be found quickly.
    task automatic read_random();
        logic [9:0] idx;
        for (int t = 0; t < 20; t++) begin
            idx = 10'($urandom_range(1023));
            if (sb.written[idx]) begin
                send_word(1'b1, 8'($urandom_range(255)), idx);
                return;
            end
        end
    endtask

    // Sends the 64 bytes in rep, with reads slipped in between some of them.
    task automatic send_report(int read_pct);
        for (int i = 0; i < 64; i++) begin
            if ($urandom_range(99) < read_pct) read_random();
            send_word(1'b0, rep[i], 10'($urandom_range(1023)));
        end
    endtask

    task automatic fill_random();
        foreach (rep[i]) rep[i] = 8'($urandom_range(255));
    endtask

    task automatic start_packet(logic [31:0] ch, logic [7:0] cmd, logic [15:0] len);
        fill_random();
        {rep[0], rep[1], rep[2], rep[3]} = ch;
        rep[4] = cmd;
        {rep[5], rep[6]} = len;
        send_report(8);
    endtask

    task automatic cont_packet(logic [31:0] ch, logic [7:0] seq);
        fill_random();
        {rep[0], rep[1], rep[2], rep[3]} = ch;
        rep[4] = seq;
        send_report(8);
    endtask

    // A start command byte that is not taken for an init request.
    function automatic logic [7:0] data_cmd();
        logic [7:0] c;
        do c = 8'($urandom_range(255, 128)); while (c == sb.init_cmd);
        return c;
    endfunction

    task automatic init_request(logic [31:0] ch);
        fill_random();
        {rep[0], rep[1], rep[2], rep[3]} = ch;
        rep[4] = sb.init_cmd;
        send_report(8);
    endtask

    // Takes the last word off the bus, waits for every expected result, then gives
    // the store drain time to finish behind a report that produced no result.
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wr_data = value;
        sb.write_reg(addr, value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    initial begin
        logic [31:0] chan;
        sb = new();
        cycles = 0;
        calm = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = hrmr_pkg::CFG_ASSIGNED_CHANNEL;
        cfg_wr_data = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // An init request with the registers still at their reset values.
        init_request($urandom);

        // The sender holds back until everything is out, then the registers move.
        settle();
        write_reg(hrmr_pkg::CFG_ASSIGNED_CHANNEL, $urandom);
        write_reg(hrmr_pkg::CFG_INIT_CODE, $urandom_range(255, 128));
        write_reg(hrmr_pkg::CFG_ERROR_CODE_CMD, $urandom_range(255, 128));

        // A message one byte longer than a start packet holds, so one continuation
        // packet completes it.
        chan = $urandom;
        start_packet(chan, data_cmd(), 16'd58);
        cont_packet(chan, sb.next_seq);
        settle();

        // Reads across the stored message, both ends included.
        send_word(1'b1, 8'hFF, 10'd0);
        send_word(1'b1, 8'h00, 10'd56);
        send_word(1'b1, 8'h00, 10'd57);
        for (int i = 0; i < 9; i++)
            send_word(1'b1, 8'($urandom_range(255)), 10'($urandom_range(57)));
        settle();

        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: hid_report_message_reassembler.f
src/hrmr_pkg.sv
src/hrmr_cmd_fifo.sv
src/hrmr_front.sv
src/hrmr_back.sv
src/hid_report_message_reassembler.sv
verif/testbench.sv
